>>> rtl/mbfa_pkg.sv
// Shared types and constants of the MSB-first bit-field access block.
`default_nettype none

package mbfa_pkg;

    // Cursor width and the largest value it may hold
    localparam int CURSOR_W   = 12;
    localparam int CURSOR_MAX = 4095;

    // Widest field one item may read or write
    localparam int MAX_FIELD_BITS = 32;

    // Action codes
    localparam int ACT_W = 2;
    localparam logic [ACT_W-1:0] ACT_READ   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_WRITE  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SET    = 2'd2;
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

endpackage

`default_nettype wire

>>> rtl/mbfa_in_if.sv
// Request channel of the bit-field access block: one access or cursor load per item.
`default_nettype none

interface mbfa_in_if
    import mbfa_pkg::*;
#(
    parameter int VAL_W = 32,
    parameter int CNT_W = 6
);
    logic                valid;
    logic                ready;
    logic [ACT_W-1:0]    action;
    logic [CNT_W-1:0]    bit_count;
    logic [VAL_W-1:0]    write_value;
    logic [CURSOR_W-1:0] position;

    modport source
    (
        output valid,
        output action,
        output bit_count,
        output write_value,
        output position,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  action,
        input  bit_count,
        input  write_value,
        input  position,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/mbfa_out_if.sv
// Response channel of the bit-field access block: one result item per request.
`default_nettype none

interface mbfa_out_if
    import mbfa_pkg::*;
#(
    parameter int VAL_W = 32
);
    logic                valid;
    logic                ready;
    logic [VAL_W-1:0]    read_value;
    logic [CURSOR_W-1:0] cursor_after;
    logic                error;

    modport source
    (
        output valid,
        output read_value,
        output cursor_after,
        output error,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  read_value,
        input  cursor_after,
        input  error,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/msb_first_bit_field_access.sv
// Top level of the MSB-first bit-field access block over a banked byte store.
`default_nettype none

// Reads or writes fields of 1 to MAX_FIELD_BITS bits at a running bit cursor in a
// byte store, bit 0 being the MSB of byte 0, or loads the cursor. When an item is
// accepted every byte bank is read at the window around the cursor; the item then
// moves to its merge state, where the window is merged and, once the output register
// is free or being taken, the touched bytes are written back and the result goes to
// the output register. A result that is not taken holds the merge, and no new item is
// accepted until the last one is through. The store is split into a power-of-two
// number of byte-wide banks, at least one per window byte, so a field spanning several
// bytes needs only one access per bank. Store contents are undefined until written;
// the cursor resets to zero. Only the first 4095 bits of the store are reachable.
module msb_first_bit_field_access
    import mbfa_pkg::*;
#(
    parameter int BUFFER_BYTES   = 256
)
(
    input  wire         clk,
    input  wire         rst_n,
    mbfa_in_if.sink     req,
    mbfa_out_if.source  rsp
);

    localparam int CNT_W      = $clog2(MAX_FIELD_BITS + 1);
    localparam int WIN_BYTES  = (MAX_FIELD_BITS + 7) / 8 + 1;
    localparam int WIN_W      = WIN_BYTES * 8;
    localparam int BANK_W     = $clog2(WIN_BYTES);
    localparam int NBANK      = 2 ** BANK_W;
    localparam int BANK_DEPTH = (BUFFER_BYTES + NBANK - 1) / NBANK;
    localparam int BADDR_W    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int IDX_W      = CURSOR_W - 3 + 1;
    localparam int SUM_W      = CURSOR_W + 1;
    localparam int SH_W       = $clog2(WIN_W + 1);
    localparam int LIMIT_I    = (BUFFER_BYTES * 8 > CURSOR_MAX) ? CURSOR_MAX : BUFFER_BYTES * 8;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic                      state_reg;
    logic                      state_next;
    logic [CURSOR_W-1:0]       cursor_reg;
    logic [CURSOR_W-1:0]       cursor_next;

    // Item held during its merge cycle
    logic [ACT_W-1:0]          act_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic [MAX_FIELD_BITS-1:0] wval_reg;
    logic [CURSOR_W-1:0]       pos_reg;

    // Output register
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [MAX_FIELD_BITS-1:0] out_value_reg;
    logic [CURSOR_W-1:0]       out_cursor_reg;
    logic                      out_error_reg;

    logic                      accept;
    logic                      exec_done;

    logic [BANK_W-1:0]         base_low;
    logic [IDX_W-1:0]          base_idx;
    logic [BADDR_W-1:0]        bank_addr [NBANK];
    logic [7:0]                rd_reg    [NBANK];
    logic                      wr_en     [NBANK];
    logic [7:0]                wr_byte   [NBANK];

    logic [WIN_W-1:0]          win;
    logic [WIN_W-1:0]          win_shl;
    logic [WIN_W-1:0]          rd_full;
    logic [WIN_W-1:0]          wmask;
    logic [WIN_W-1:0]          wdata;
    logic [WIN_W-1:0]          new_win;
    logic [SH_W-1:0]           rd_sh;
    logic [SH_W-1:0]           wr_sh;
    logic [MAX_FIELD_BITS:0]   one_sh;
    logic [MAX_FIELD_BITS-1:0] fmask;
    logic [SUM_W-1:0]          field_end;
    logic [SUM_W-1:0]          limit;

    logic                      width_ok;
    logic                      access_ok;
    logic                      set_ok;
    logic                      item_err;
    logic                      do_write;

    // Handshake
    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign exec_done = (state_reg == ST_EXEC) && (!out_valid_reg || rsp.ready);

    // Window position within the banks
    assign base_low = cursor_reg[BANK_W+2:3];
    assign base_idx = IDX_W'(cursor_reg[CURSOR_W-1:3]);

    // Address each bank at the window byte that falls in it
    always_comb
    begin
        logic [BANK_W-1:0] j;
        logic [IDX_W-1:0]  idx;
        for (int b = 0; b < NBANK; b++)
        begin
            j            = BANK_W'(b) - base_low;
            idx          = base_idx + IDX_W'(j);
            bank_addr[b] = BADDR_W'(idx >> BANK_W);
        end
    end

    // Byte banks: read at accept, write back on merge
    for (genvar gb = 0; gb < NBANK; gb++)
    begin : g_bank
        logic [7:0] mem [BANK_DEPTH];

        always_ff @(posedge clk)
        begin
            if (wr_en[gb])
            begin
                mem[bank_addr[gb]] <= wr_byte[gb];
            end
            if (accept)
            begin
                rd_reg[gb] <= mem[bank_addr[gb]];
            end
        end
    end

    // Assemble the window, first byte most significant
    always_comb
    begin
        logic [BANK_W-1:0] bk;
        win = '0;
        for (int j = 0; j < WIN_BYTES; j++)
        begin
            bk = base_low + BANK_W'(j);
            win[WIN_W-1-8*j -: 8] = rd_reg[bk];
        end
    end

    // Check width, store end and cursor range
    assign limit     = SUM_W'(LIMIT_I);
    assign field_end = SUM_W'(cursor_reg) + SUM_W'(cnt_reg);
    assign width_ok  = (cnt_reg != '0) && (cnt_reg <= CNT_W'(MAX_FIELD_BITS));
    assign access_ok = ((act_reg == ACT_READ) || (act_reg == ACT_WRITE)) && width_ok
                       && (field_end <= limit);
    assign set_ok    = (act_reg == ACT_SET) && (SUM_W'(pos_reg) <= limit);
    assign item_err  = !(access_ok || set_ok);
    assign do_write  = exec_done && access_ok && (act_reg == ACT_WRITE);

    // Extract the field right-aligned
    assign win_shl = win << cursor_reg[2:0];
    assign rd_sh   = SH_W'(WIN_W) - SH_W'(cnt_reg);
    assign rd_full = win_shl >> rd_sh;

    // Place the masked write value in the window
    assign one_sh  = (MAX_FIELD_BITS + 1)'(1) << cnt_reg;
    assign fmask   = MAX_FIELD_BITS'(one_sh - (MAX_FIELD_BITS + 1)'(1));
    assign wr_sh   = SH_W'(WIN_W) - SH_W'(cursor_reg[2:0]) - SH_W'(cnt_reg);
    assign wmask   = WIN_W'(fmask) << wr_sh;
    assign wdata   = WIN_W'(wval_reg & fmask) << wr_sh;
    assign new_win = (win & ~wmask) | wdata;

    // Write back only the bytes the field touches
    always_comb
    begin
        logic [BANK_W-1:0] bk;
        for (int b = 0; b < NBANK; b++)
        begin
            wr_en[b]   = 1'b0;
            wr_byte[b] = '0;
        end
        for (int j = 0; j < WIN_BYTES; j++)
        begin
            bk          = base_low + BANK_W'(j);
            wr_en[bk]   = do_write && (|wmask[WIN_W-1-8*j -: 8]);
            wr_byte[bk] = new_win[WIN_W-1-8*j -: 8];
        end
    end

    // Sequence and cursor
    always_comb
    begin
        state_next     = state_reg;
        cursor_next    = cursor_reg;
        out_valid_next = out_valid_reg;
        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (exec_done)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    if (set_ok)
                    begin
                        cursor_next = pos_reg;
                    end
                    else if (access_ok)
                    begin
                        cursor_next = field_end[CURSOR_W-1:0];
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cursor_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the item and the result
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg  <= req.action;
            cnt_reg  <= req.bit_count;
            wval_reg <= req.write_value;
            pos_reg  <= req.position;
        end
        if (exec_done)
        begin
            out_value_reg  <= (access_ok && (act_reg == ACT_READ))
                              ? rd_full[MAX_FIELD_BITS-1:0] : '0;
            out_cursor_reg <= cursor_next;
            out_error_reg  <= item_err;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.read_value   = out_value_reg;
    assign rsp.cursor_after = out_cursor_reg;
    assign rsp.error        = out_error_reg;

endmodule

`default_nettype wire
